// ===== sv/lmls_pkg.sv =====
package lmls_pkg;

    localparam int ACC_W      = 13;
    localparam int LINE_W     = 8;
    localparam int DELTA_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [ACC_W-1:0]  RST_ACCUM = 13'd4500;
    localparam logic [LINE_W-1:0] RST_LINE  = 8'd153;

    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COINC_IRQ_EN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_EN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VBLANK_IRQ_EN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_IRQ_EN  = 3'd5;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    typedef struct packed {
        logic              display_enable;
        logic [LINE_W-1:0] line_compare;
        logic              coincidence_irq_enable;
        logic              hblank_irq_enable;
        logic              vblank_irq_enable;
        logic              search_irq_enable;
    } cfg_t;

    typedef struct packed {
        lcd_mode_t         mode;
        logic [LINE_W-1:0] line;
        logic [ACC_W-1:0]  accum;
        logic              coincidence;
    } state_t;

    typedef struct packed {
        lcd_mode_t         mode;
        logic [LINE_W-1:0] line;
        logic              coincidence;
        logic              vblank_irq;
        logic              status_irq;
        logic              line_render;
        logic              frame_done;
    } result_t;

endpackage

// ===== sv/lmls_step.sv =====
module lmls_step import lmls_pkg::*; #(
    parameter int HBLANK_LEN    = 204,
    parameter int VBLANK_LEN    = 4560,
    parameter int SEARCH_LEN    = 80,
    parameter int TRANSFER_LEN  = 172,
    parameter int LINE_LEN      = 456,
    parameter int VISIBLE_LINES = 144,
    parameter int PHASE_W       = 9
) (
    input  cfg_t               cfg,
    input  state_t             state,
    input  logic [PHASE_W-1:0] phase,
    input  logic [DELTA_W-1:0] delta,
    output state_t             state_next,
    output logic [PHASE_W-1:0] phase_next,
    output result_t            result
);

    localparam int SUM_W = ACC_W + 1;

    localparam logic [PHASE_W:0] LEN_P   = (PHASE_W+1)'(LINE_LEN);
    localparam logic [PHASE_W:0] HB_MOD  = (PHASE_W+1)'(HBLANK_LEN % LINE_LEN);
    localparam logic [PHASE_W:0] VB_MOD  = (PHASE_W+1)'(VBLANK_LEN % LINE_LEN);
    localparam logic [PHASE_W:0] TR_MOD  = (PHASE_W+1)'(TRANSFER_LEN % LINE_LEN);

    localparam logic [SUM_W-1:0] HB_LEN  = SUM_W'(HBLANK_LEN);
    localparam logic [SUM_W-1:0] VB_LEN  = SUM_W'(VBLANK_LEN);
    localparam logic [SUM_W-1:0] SR_LEN  = SUM_W'(SEARCH_LEN);
    localparam logic [SUM_W-1:0] TR_LEN  = SUM_W'(TRANSFER_LEN);
    localparam logic [LINE_W-1:0] VIS    = LINE_W'(VISIBLE_LINES);

    localparam int DELTA_N = 2 ** DELTA_W;

    // delta mod LINE_LEN for every possible delta
    function automatic logic [DELTA_N*PHASE_W-1:0] build_dmod();
        logic [DELTA_N*PHASE_W-1:0] t;
        t = '0;
        for (int i = 0; i < DELTA_N; i++) begin
            t[i*PHASE_W +: PHASE_W] = PHASE_W'(i % LINE_LEN);
        end
        return t;
    endfunction

    localparam logic [DELTA_N*PHASE_W-1:0] DMOD_TABLE = build_dmod();

    logic [SUM_W-1:0]   sum;
    logic [PHASE_W-1:0] dmod;
    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W:0]   phase_acc;
    logic [PHASE_W:0]   phase_hb;
    logic [PHASE_W:0]   phase_vb;
    logic [PHASE_W:0]   phase_tr;
    logic [LINE_W-1:0]  line_inc;
    logic               bumped;

    always_comb begin
        sum       = {1'b0, state.accum} + SUM_W'(delta);
        dmod      = DMOD_TABLE[delta*PHASE_W +: PHASE_W];
        phase_sum = {1'b0, phase} + {1'b0, dmod};
        phase_acc = (phase_sum >= LEN_P) ? phase_sum - LEN_P : phase_sum;
        phase_hb  = (phase_acc >= HB_MOD) ? phase_acc - HB_MOD : phase_acc + LEN_P - HB_MOD;
        phase_vb  = (phase_acc >= VB_MOD) ? phase_acc - VB_MOD : phase_acc + LEN_P - VB_MOD;
        phase_tr  = (phase_acc >= TR_MOD) ? phase_acc - TR_MOD : phase_acc + LEN_P - TR_MOD;
        line_inc  = state.line + LINE_W'(1);

        state_next        = state;
        state_next.accum  = sum[ACC_W-1:0];
        phase_next        = phase_acc[PHASE_W-1:0];
        bumped            = 1'b0;
        result.vblank_irq = 1'b0;
        result.status_irq = 1'b0;
        result.line_render = 1'b0;
        result.frame_done = 1'b0;

        if (!cfg.display_enable) begin
            state_next.mode  = MODE_HBLANK;
            state_next.line  = '0;
            state_next.accum = '0;
            phase_next       = '0;
        end else begin
            unique case (state.mode)
                MODE_HBLANK: begin
                    if (sum >= HB_LEN) begin
                        state_next.accum = ACC_W'(sum - HB_LEN);
                        phase_next       = phase_hb[PHASE_W-1:0];
                        state_next.line  = line_inc;
                        bumped           = 1'b1;
                        if (line_inc == VIS) begin
                            state_next.mode   = MODE_VBLANK;
                            result.frame_done = 1'b1;
                            result.vblank_irq = 1'b1;
                            result.status_irq = cfg.vblank_irq_enable;
                        end else begin
                            state_next.mode   = MODE_SEARCH;
                            result.status_irq = cfg.search_irq_enable;
                        end
                    end
                end
                MODE_VBLANK: begin
                    if (sum >= VB_LEN) begin
                        state_next.accum = ACC_W'(sum - VB_LEN);
                        phase_next       = phase_vb[PHASE_W-1:0];
                        state_next.mode  = MODE_SEARCH;
                        state_next.line  = '0;
                        bumped           = 1'b1;
                    end else if (phase_acc[PHASE_W-1:0] < phase) begin
                        state_next.line = line_inc;
                        bumped          = 1'b1;
                    end
                end
                MODE_SEARCH: begin
                    if (sum >= SR_LEN) begin
                        state_next.mode  = MODE_TRANSFER;
                        state_next.accum = '0;
                        phase_next       = '0;
                    end
                end
                MODE_TRANSFER: begin
                    if (sum >= TR_LEN) begin
                        state_next.accum   = ACC_W'(sum - TR_LEN);
                        phase_next         = phase_tr[PHASE_W-1:0];
                        state_next.mode    = MODE_HBLANK;
                        result.line_render = 1'b1;
                        result.status_irq  = cfg.hblank_irq_enable;
                    end
                end
            endcase
            state_next.coincidence = (state_next.line == cfg.line_compare);
            if (bumped && state_next.coincidence && cfg.coincidence_irq_enable) begin
                result.status_irq = 1'b1;
            end
        end

        result.mode        = state_next.mode;
        result.line        = state_next.line;
        result.coincidence = state_next.coincidence;
    end

endmodule

// ===== sv/lcd_mode_line_sequencer_unit.sv =====
// Each accepted item's result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one item per cycle while s_ready is high; the timing step is a single pass of
// add/compare logic between the state registers and the result register.
// A two-entry result buffer keeps s_ready high while one result waits.
// Reset (aresetn low, synchronous): vertical blank, line 153, cycle count 4500,
// display on, other configuration registers zero, result buffer empty.
module lcd_mode_line_sequencer_unit import lmls_pkg::*; #(
    parameter int HBLANK_LEN    = 204,
    parameter int VBLANK_LEN    = 4560,
    parameter int SEARCH_LEN    = 80,
    parameter int TRANSFER_LEN  = 172,
    parameter int LINE_LEN      = 456,
    parameter int VISIBLE_LINES = 144
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DELTA_W-1:0]    s_elapsed_cycles,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_lcd_mode,
    output logic [LINE_W-1:0]     m_line_number,
    output logic                  m_coincidence,
    output logic                  m_vblank_irq,
    output logic                  m_status_irq,
    output logic                  m_line_render,
    output logic                  m_frame_done
);

    localparam int PHASE_W = $clog2(LINE_LEN + 1);
    localparam logic [PHASE_W-1:0] RST_PHASE = PHASE_W'(int'(RST_ACCUM) % LINE_LEN);

    cfg_t               cfg_reg;
    state_t             state_reg;
    state_t             state_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    result_t            result_next;
    result_t            out_reg;
    result_t            skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               in_fire;
    logic               out_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign in_fire   = s_valid && s_ready;
    assign out_fire  = out_valid_reg && m_ready;

    lmls_step #(
        .HBLANK_LEN    (HBLANK_LEN),
        .VBLANK_LEN    (VBLANK_LEN),
        .SEARCH_LEN    (SEARCH_LEN),
        .TRANSFER_LEN  (TRANSFER_LEN),
        .LINE_LEN      (LINE_LEN),
        .VISIBLE_LINES (VISIBLE_LINES),
        .PHASE_W       (PHASE_W)
    ) u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .phase      (phase_reg),
        .delta      (s_elapsed_cycles),
        .state_next (state_next),
        .phase_next (phase_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.display_enable         <= 1'b1;
            cfg_reg.line_compare           <= '0;
            cfg_reg.coincidence_irq_enable <= 1'b0;
            cfg_reg.hblank_irq_enable      <= 1'b0;
            cfg_reg.vblank_irq_enable      <= 1'b0;
            cfg_reg.search_irq_enable      <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DISPLAY_ENABLE: cfg_reg.display_enable         <= cfg_data[0];
                REG_LINE_COMPARE:   cfg_reg.line_compare           <= cfg_data;
                REG_COINC_IRQ_EN:   cfg_reg.coincidence_irq_enable <= cfg_data[0];
                REG_HBLANK_IRQ_EN:  cfg_reg.hblank_irq_enable      <= cfg_data[0];
                REG_VBLANK_IRQ_EN:  cfg_reg.vblank_irq_enable      <= cfg_data[0];
                REG_SEARCH_IRQ_EN:  cfg_reg.search_irq_enable      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode        <= MODE_VBLANK;
            state_reg.line        <= RST_LINE;
            state_reg.accum       <= RST_ACCUM;
            state_reg.coincidence <= 1'b0;
            phase_reg             <= RST_PHASE;
        end else if (in_fire) begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // two-entry result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_reg <= skid_reg;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !m_ready) begin
                skid_reg <= result_next;
            end else begin
                out_reg <= result_next;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_lcd_mode    = out_reg.mode;
    assign m_line_number = out_reg.line;
    assign m_coincidence = out_reg.coincidence;
    assign m_vblank_irq  = out_reg.vblank_irq;
    assign m_status_irq  = out_reg.status_irq;
    assign m_line_render = out_reg.line_render;
    assign m_frame_done  = out_reg.frame_done;

endmodule

// ===== verif/lmls_tb_pkg.sv =====
package lmls_tb_pkg;
    import lmls_pkg::*;

    localparam int HBLANK_LEN    = 204;
    localparam int VBLANK_LEN    = 4560;
    localparam int SEARCH_LEN    = 80;
    localparam int TRANSFER_LEN  = 172;
    localparam int LINE_LEN      = 456;
    localparam int VISIBLE_LINES = 144;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI       = 3'd7;

    localparam int MAX_REPORTS = 30;

    class lcd_timing_scoreboard;
        cfg_t              regs;
        lcd_mode_t         mode;
        logic [LINE_W-1:0] line;
        int unsigned       accum;
        logic              coinc;
        result_t           expected_status_q[$];
        int errors;
        int ticks;
        int results;
        int frames;
        int ticks_since_frame;
        int renders;
        int status_irqs;
        int vblank_irqs;
        int coinc_results;

        function new();
            regs.display_enable         = 1'b1;
            regs.line_compare           = '0;
            regs.coincidence_irq_enable = 1'b0;
            regs.hblank_irq_enable      = 1'b0;
            regs.vblank_irq_enable      = 1'b0;
            regs.search_irq_enable      = 1'b0;
            mode  = MODE_VBLANK;
            line  = RST_LINE;
            accum = RST_ACCUM;
            coinc = 1'b0;
            errors = 0;
            ticks = 0;
            results = 0;
            frames = 0;
            ticks_since_frame = 0;
            renders = 0;
            status_irqs = 0;
            vblank_irqs = 0;
            coinc_results = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DISPLAY_ENABLE: regs.display_enable         = data[0];
                REG_LINE_COMPARE:   regs.line_compare           = data;
                REG_COINC_IRQ_EN:   regs.coincidence_irq_enable = data[0];
                REG_HBLANK_IRQ_EN:  regs.hblank_irq_enable      = data[0];
                REG_VBLANK_IRQ_EN:  regs.vblank_irq_enable      = data[0];
                REG_SEARCH_IRQ_EN:  regs.search_irq_enable      = data[0];
                default: ;
            endcase
        endfunction

        function logic bump_line(logic [LINE_W-1:0] nxt);
            line  = nxt;
            coinc = (line == regs.line_compare);
            return coinc && regs.coincidence_irq_enable;
        endfunction

        function void predict_tick(logic [DELTA_W-1:0] elapsed);
            result_t     want;
            int unsigned prev;
            int unsigned acc;
            logic        vb;
            logic        st;
            logic        render;
            logic        frame;
            vb = 1'b0;
            st = 1'b0;
            render = 1'b0;
            frame = 1'b0;
            if (!regs.display_enable) begin
                mode  = MODE_HBLANK;
                line  = '0;
                accum = 0;
            end else begin
                prev = accum;
                acc  = prev + elapsed;
                case (mode)
                    MODE_HBLANK: begin
                        if (acc >= HBLANK_LEN) begin
                            acc -= HBLANK_LEN;
                            st = st | bump_line(line + 8'd1);
                            if (line == VISIBLE_LINES) begin
                                frame = 1'b1;
                                mode  = MODE_VBLANK;
                                vb    = 1'b1;
                                if (regs.vblank_irq_enable) st = 1'b1;
                            end else begin
                                mode = MODE_SEARCH;
                                if (regs.search_irq_enable) st = 1'b1;
                            end
                        end
                    end
                    MODE_VBLANK: begin
                        if (acc >= VBLANK_LEN) begin
                            acc -= VBLANK_LEN;
                            mode = MODE_SEARCH;
                            st = st | bump_line(8'd0);
                        end else if (acc % LINE_LEN < prev % LINE_LEN) begin
                            st = st | bump_line(line + 8'd1);
                        end
                    end
                    MODE_SEARCH: begin
                        if (acc >= SEARCH_LEN) begin
                            mode = MODE_TRANSFER;
                            acc  = 0;
                        end
                    end
                    default: begin
                        if (acc >= TRANSFER_LEN) begin
                            acc -= TRANSFER_LEN;
                            mode   = MODE_HBLANK;
                            render = 1'b1;
                            if (regs.hblank_irq_enable) st = 1'b1;
                        end
                    end
                endcase
                accum = acc & 32'h1FFF;
                coinc = (line == regs.line_compare);
            end
            want.mode        = mode;
            want.line        = line;
            want.coincidence = coinc;
            want.vblank_irq  = vb;
            want.status_irq  = st;
            want.line_render = render;
            want.frame_done  = frame;
            expected_status_q.push_back(want);
            ticks++;
            ticks_since_frame++;
            if (frame) begin
                frames++;
                ticks_since_frame = 0;
            end
            if (render) renders++;
            if (st) status_irqs++;
            if (vb) vblank_irqs++;
            if (coinc) coinc_results++;
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            if (errors < MAX_REPORTS)
                $display("[%0t] result %0d: %s got %0d, expected %0d",
                         $time, results, what, got, want);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_status_q.size() == 0) begin
                report_mismatch("item with nothing pending", 1, 0);
            end else begin
                want = expected_status_q.pop_front();
                if (got.mode !== want.mode)
                    report_mismatch("lcd_mode", got.mode, want.mode);
                if (got.line !== want.line)
                    report_mismatch("line_number", got.line, want.line);
                if (got.coincidence !== want.coincidence)
                    report_mismatch("coincidence", got.coincidence, want.coincidence);
                if (got.vblank_irq !== want.vblank_irq)
                    report_mismatch("vblank_irq", got.vblank_irq, want.vblank_irq);
                if (got.status_irq !== want.status_irq)
                    report_mismatch("status_irq", got.status_irq, want.status_irq);
                if (got.line_render !== want.line_render)
                    report_mismatch("line_render", got.line_render, want.line_render);
                if (got.frame_done !== want.frame_done)
                    report_mismatch("frame_done", got.frame_done, want.frame_done);
            end
            results++;
        endtask
    endclass

endpackage

// ===== verif/tb_lcd_mode_line_sequencer_unit.sv =====
module tb_lcd_mode_line_sequencer_unit;
    import lmls_pkg::*;
    import lmls_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 64;
    localparam int MIN_RANDOM  = 1300;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [DELTA_W-1:0]    s_elapsed_cycles = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_lcd_mode;
    logic [LINE_W-1:0]     m_line_number;
    logic                  m_coincidence;
    logic                  m_vblank_irq;
    logic                  m_status_irq;
    logic                  m_line_render;
    logic                  m_frame_done;

    lcd_timing_scoreboard sb = new();
    bit hold_req = 1'b0;
    int random_ticks = 0;
    int settings = 0;

    lcd_mode_line_sequencer_unit #(
        .HBLANK_LEN   (HBLANK_LEN),
        .VBLANK_LEN   (VBLANK_LEN),
        .SEARCH_LEN   (SEARCH_LEN),
        .TRANSFER_LEN (TRANSFER_LEN),
        .LINE_LEN     (LINE_LEN),
        .VISIBLE_LINES(VISIBLE_LINES)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_elapsed_cycles(s_elapsed_cycles),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lcd_mode      (m_lcd_mode),
        .m_line_number   (m_line_number),
        .m_coincidence   (m_coincidence),
        .m_vblank_irq    (m_vblank_irq),
        .m_status_irq    (m_status_irq),
        .m_line_render   (m_line_render),
        .m_frame_done    (m_frame_done)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: segments of varying stall density, plus one long hold-off on request
    initial begin
        int seg_len;
        int stall_pct;
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            seg_len = $urandom_range(8, 120);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
            repeat (seg_len) begin
                @(posedge aclk);
                if (hold_req && !hold_done && hold_left == 0) hold_left = LONG_HOLD;
                if (hold_left > 0) begin
                    m_ready <= 1'b0;
                    hold_left--;
                    if (hold_left == 0) hold_done = 1'b1;
                end else begin
                    m_ready <= ($urandom_range(0, 99) >= stall_pct);
                end
            end
        end
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.mode        = lcd_mode_t'(m_lcd_mode);
            got.line        = m_line_number;
            got.coincidence = m_coincidence;
            got.vblank_irq  = m_vblank_irq;
            got.status_irq  = m_status_irq;
            got.line_render = m_line_render;
            got.frame_done  = m_frame_done;
            sb.check_result(got);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("lcd_mode_line_sequencer_unit test failed");
        $finish;
    end

    function automatic logic [CFG_DATA_W-1:0] pad_bit(input logic b);
        if ($urandom_range(0, 1)) return {7'($urandom_range(0, 127)), b};
        return {7'd0, b};
    endfunction

    function automatic logic [DELTA_W-1:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return DELTA_W'($urandom_range(24, 31));
        if (r < 88) return DELTA_W'($urandom_range(0, 31));
        if (r < 94) return '0;
        return DELTA_W'($urandom_range(1, 3));
    endfunction

    // caller lowers cfg_valid after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs(input cfg_t c);
        write_reg(REG_DISPLAY_ENABLE, pad_bit(c.display_enable));
        write_reg(REG_LINE_COMPARE, c.line_compare);
        write_reg(REG_COINC_IRQ_EN, pad_bit(c.coincidence_irq_enable));
        write_reg(REG_HBLANK_IRQ_EN, pad_bit(c.hblank_irq_enable));
        write_reg(REG_VBLANK_IRQ_EN, pad_bit(c.vblank_irq_enable));
        write_reg(REG_SEARCH_IRQ_EN, pad_bit(c.search_irq_enable));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        settings++;
    endtask

    task automatic wait_idle();
        while (sb.pending() > 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // caller lowers s_valid when the stream pauses
    task automatic send_tick(input logic [DELTA_W-1:0] elapsed);
        s_valid          <= 1'b1;
        s_elapsed_cycles <= elapsed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.predict_tick(elapsed);
    endtask

    task automatic run_stream(input int n_items);
        int left;
        int burst;
        left = n_items;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            repeat (burst) send_tick(pick_elapsed());
            left -= burst;
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        static logic [DELTA_W-1:0] first_ticks[16] = '{5'd0, 5'd31, 5'd31, 5'd31, 5'd31,
                                                       5'd31, 5'd31, 5'd31, 5'd21, 5'd10,
                                                       5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
                                                       5'd31};
        static logic [LINE_W-1:0] compare_picks[9] = '{8'd0, 8'd1, 8'd143, 8'd144, 8'd145,
                                                      8'd150, 8'd153, 8'd154, 8'd255};
        cfg_t cfg;
        int phase;
        int n;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every interrupt source on, compare at line 0
        cfg = '{display_enable: 1'b1, line_compare: 8'd0, coincidence_irq_enable: 1'b1,
                hblank_irq_enable: 1'b1, vblank_irq_enable: 1'b1, search_irq_enable: 1'b1};
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 255)));
        program_regs(cfg);
        foreach (first_ticks[i]) send_tick(first_ticks[i]);
        s_valid <= 1'b0;
        @(posedge aclk);

        // display off: counters held at zero, coincidence keeps its last value
        wait_idle();
        cfg.display_enable = 1'b0;
        cfg.line_compare   = 8'd255;
        program_regs(cfg);
        send_tick(5'd31);
        send_tick(5'd0);
        send_tick(5'd17);
        s_valid <= 1'b0;
        @(posedge aclk);

        wait_idle();
        cfg = '{display_enable: 1'b1, line_compare: 8'd0, coincidence_irq_enable: 1'b0,
                hblank_irq_enable: 1'b0, vblank_irq_enable: 1'b0, search_irq_enable: 1'b0};
        program_regs(cfg);
        send_tick(5'd31);
        send_tick(5'd0);
        send_tick(5'd14);
        s_valid <= 1'b0;
        @(posedge aclk);

        // random phases of register settings
        phase = 0;
        while (random_ticks < MIN_RANDOM) begin
            wait_idle();
            cfg.display_enable = (phase != 1 && phase != 3);
            if (phase == 0)
                cfg.line_compare = 8'd255;
            else if ($urandom_range(0, 2) == 0)
                cfg.line_compare = LINE_W'($urandom_range(0, 255));
            else
                cfg.line_compare = compare_picks[$urandom_range(0, 8)];
            cfg.coincidence_irq_enable = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            cfg.hblank_irq_enable      = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            cfg.vblank_irq_enable      = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            cfg.search_irq_enable      = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            program_regs(cfg);
            if (phase == 2) hold_req = 1'b1;
            n = cfg.display_enable ? $urandom_range(150, 300) : $urandom_range(30, 60);
            run_stream(n);
            random_ticks += n;
            phase++;
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        $display("Ran %0d ticks (%0d random) over %0d register settings; %0d frames,",
                 sb.ticks, random_ticks, settings, sb.frames);
        $display("%0d rendered lines, %0d status irqs, %0d vblank irqs, %0d mismatches.",
                 sb.renders, sb.status_irqs, sb.vblank_irqs, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("lcd_mode_line_sequencer_unit test passed");
        else
            $display("lcd_mode_line_sequencer_unit test failed");
        $finish;
    end

endmodule
